[rtl/bfba_pkg.sv]
// ----------------------------------------------------------------------------
// Best-fit block allocator package
// Table sizing, header size, status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfba_pkg;

    localparam int HEADER_BYTES   = 8;
    localparam int MAX_BLOCKS     = 64;
    localparam int POOL_MAX_BYTES = 65536;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = IDX_W + 1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef logic [16:0] addr_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_BADFREE = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN_A,
        S_SCAN_B,
        S_WR_SPLIT,
        S_WR_BEST,
        S_WR_FREE,
        S_RESULT
    } state_t;

    typedef enum logic {
        PH_FIND,
        PH_NEIGHBOR
    } phase_t;

    typedef struct packed {
        logic    accept;
        logic    scan_clear;
        logic    scan_rewind;
        logic    scan_en;
        phase_t  phase;
        logic    init;
        logic    wr_split;
        logic    wr_best;
        logic    wr_free;
        logic    result_load;
        status_t status;
    } cmd_t;

    typedef struct packed {
        logic cfg_wr;
        logic kind;
        logic null_off;
        logic scan_done;
        logic best_found;
        logic need_split;
        logic slot_found;
        logic me_ok;
        logic out_busy;
    } sts_t;

endpackage

[rtl/bfba_datapath.sv]
// ----------------------------------------------------------------------------
// Best-fit block allocator datapath
// Block table memories, valid/used bits, table scan with trackers for the
// best fit, free slot and neighbors, table updates and the result register.
// ----------------------------------------------------------------------------
module bfba_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [16:0]       cfg_pool_size,
    input  logic              s_kind,
    input  logic [16:0]       s_request_size,
    input  logic [15:0]       s_block_offset,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [15:0]       m_payload_offset,
    output logic [1:0]        m_status,
    input  bfba_pkg::cmd_t    cmd,
    output bfba_pkg::sts_t    sts
);
    import bfba_pkg::*;

    localparam logic [16:0] HDR17 = 17'(HEADER_BYTES);
    localparam logic [17:0] HDR18 = 18'(HEADER_BYTES);
    localparam logic [16:0] PMAX  = 17'(POOL_MAX_BYTES);

    logic [16:0] pool_reg;
    logic        kind_reg;
    logic [16:0] req_reg;
    logic [15:0] off_reg;

    addr_t start_mem [MAX_BLOCKS];
    addr_t len_mem   [MAX_BLOCKS];
    addr_t start_q_reg, len_q_reg;

    logic [MAX_BLOCKS-1:0] valid_reg, used_reg;
    logic [MAX_BLOCKS-1:0] drop_mask;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rd_pend_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_go;

    logic             best_found_reg, best_found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    addr_t            best_start_reg, best_start_next;
    addr_t            best_len_reg, best_len_next;
    logic             slot_found_reg, slot_found_next;
    logic [IDX_W-1:0] slot_idx_reg, slot_idx_next;
    logic             me_found_reg, me_found_next;
    logic [IDX_W-1:0] me_idx_reg, me_idx_next;
    addr_t            me_start_reg, me_start_next;
    addr_t            me_len_reg, me_len_next;
    logic             nb_found_reg, nb_found_next;
    logic [IDX_W-1:0] nb_idx_reg, nb_idx_next;
    addr_t            nb_len_reg, nb_len_next;
    logic             nb_used_reg, nb_used_next;
    logic             left_found_reg, left_found_next;
    logic [IDX_W-1:0] left_idx_reg, left_idx_next;
    addr_t            left_len_reg, left_len_next;

    logic             m_valid_reg;
    logic [15:0]      m_off_reg;
    status_t          m_status_reg;

    logic             q_valid, q_used;
    logic [17:0]      q_end, me_end;
    addr_t            pool_eff;
    logic             need_split, merge;
    addr_t            merged_len;

    logic             we_start, we_len;
    logic [IDX_W-1:0] wr_idx;
    addr_t            wr_start, wr_len;

    assign pool_eff   = (pool_reg > PMAX) ? PMAX : pool_reg;
    assign q_valid    = valid_reg[rd_idx_reg];
    assign q_used     = used_reg[rd_idx_reg];
    assign q_end      = {1'b0, start_q_reg} + {1'b0, len_q_reg} + HDR18;
    assign me_end     = {1'b0, me_start_reg} + {1'b0, me_len_reg} + HDR18;
    assign need_split = ({1'b0, req_reg} + HDR18) < {1'b0, best_len_reg};
    assign merge      = nb_found_reg && !nb_used_reg;
    assign merged_len = merge ? me_len_reg + nb_len_reg + HDR17 : me_len_reg;
    assign rd_go      = cmd.scan_en && (cnt_reg < CNT_W'(MAX_BLOCKS));
    assign drop_mask  = (merge ? (MAX_BLOCKS'(1) << nb_idx_reg) : '0) |
                        (left_found_reg ? (MAX_BLOCKS'(1) << me_idx_reg) : '0);

    // configuration and captured request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg <= PMAX;
        end else if (cfg_valid) begin
            pool_reg <= cfg_pool_size;
        end
        if (cmd.accept) begin
            kind_reg <= s_kind;
            req_reg  <= s_request_size;
            off_reg  <= s_block_offset;
        end
    end

    // table write select
    always_comb begin
        we_start = 1'b0;
        we_len   = 1'b0;
        wr_idx   = '0;
        wr_start = HDR17;
        wr_len   = pool_eff - HDR17;
        if (cmd.init) begin
            we_start = 1'b1;
            we_len   = 1'b1;
        end else if (cmd.wr_split) begin
            we_start = 1'b1;
            we_len   = 1'b1;
            wr_idx   = slot_idx_reg;
            wr_start = best_start_reg + req_reg + HDR17;
            wr_len   = best_len_reg - req_reg - HDR17;
        end else if (cmd.wr_best) begin
            we_len   = 1'b1;
            wr_idx   = best_idx_reg;
            wr_len   = need_split ? req_reg : best_len_reg;
        end else if (cmd.wr_free) begin
            if (left_found_reg) begin
                we_len = 1'b1;
                wr_idx = left_idx_reg;
                wr_len = left_len_reg + merged_len + HDR17;
            end else if (merge) begin
                we_len = 1'b1;
                wr_idx = me_idx_reg;
                wr_len = merged_len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we_start) begin
            start_mem[wr_idx] <= wr_start;
        end
        if (we_len) begin
            len_mem[wr_idx] <= wr_len;
        end
        start_q_reg <= start_mem[cnt_reg[IDX_W-1:0]];
        len_q_reg   <= len_mem[cnt_reg[IDX_W-1:0]];
    end

    // valid and used bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            used_reg  <= '0;
        end else if (cmd.init) begin
            valid_reg <= MAX_BLOCKS'(pool_eff > HDR17);
            used_reg  <= '0;
        end else if (cmd.wr_split) begin
            valid_reg[slot_idx_reg] <= 1'b1;
            used_reg[slot_idx_reg]  <= 1'b0;
        end else if (cmd.wr_best) begin
            used_reg[best_idx_reg] <= 1'b1;
        end else if (cmd.wr_free) begin
            used_reg[me_idx_reg] <= 1'b0;
            // drop the absorbed right neighbor and the block merged into its left
            valid_reg <= valid_reg & ~drop_mask;
        end
    end

    // scan trackers
    always_comb begin
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        slot_found_next = slot_found_reg;
        slot_idx_next   = slot_idx_reg;
        me_found_next   = me_found_reg;
        me_idx_next     = me_idx_reg;
        me_start_next   = me_start_reg;
        me_len_next     = me_len_reg;
        nb_found_next   = nb_found_reg;
        nb_idx_next     = nb_idx_reg;
        nb_len_next     = nb_len_reg;
        nb_used_next    = nb_used_reg;
        left_found_next = left_found_reg;
        left_idx_next   = left_idx_reg;
        left_len_next   = left_len_reg;
        if (rd_pend_reg) begin
            if (cmd.phase == PH_FIND) begin
                if (kind_reg == KIND_ALLOC) begin
                    if (q_valid && !q_used && len_q_reg >= req_reg &&
                        (!best_found_reg || len_q_reg < best_len_reg ||
                         (len_q_reg == best_len_reg && start_q_reg < best_start_reg))) begin
                        best_found_next = 1'b1;
                        best_idx_next   = rd_idx_reg;
                        best_start_next = start_q_reg;
                        best_len_next   = len_q_reg;
                    end
                    if (!q_valid && !slot_found_reg) begin
                        slot_found_next = 1'b1;
                        slot_idx_next   = rd_idx_reg;
                    end
                end else if (q_valid && !me_found_reg && start_q_reg == {1'b0, off_reg}) begin
                    me_found_next = 1'b1;
                    me_idx_next   = rd_idx_reg;
                    me_start_next = start_q_reg;
                    me_len_next   = len_q_reg;
                end
            end else begin
                if (q_valid && !nb_found_reg && {1'b0, start_q_reg} == me_end) begin
                    nb_found_next = 1'b1;
                    nb_idx_next   = rd_idx_reg;
                    nb_len_next   = len_q_reg;
                    nb_used_next  = q_used;
                end
                if (q_valid && !q_used && !left_found_reg && rd_idx_reg != me_idx_reg &&
                    q_end == {1'b0, me_start_reg}) begin
                    left_found_next = 1'b1;
                    left_idx_next   = rd_idx_reg;
                    left_len_next   = len_q_reg;
                end
            end
        end
        if (cmd.scan_clear) begin
            best_found_next = 1'b0;
            slot_found_next = 1'b0;
            me_found_next   = 1'b0;
        end
        if (cmd.scan_clear || cmd.scan_rewind) begin
            nb_found_next   = 1'b0;
            left_found_next = 1'b0;
        end
        if (cmd.scan_clear || cmd.scan_rewind) begin
            cnt_next = '0;
        end else if (rd_go) begin
            cnt_next = cnt_reg + 1'b1;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            slot_found_reg <= 1'b0;
            me_found_reg   <= 1'b0;
            nb_found_reg   <= 1'b0;
            left_found_reg <= 1'b0;
        end else begin
            cnt_reg        <= cnt_next;
            rd_pend_reg    <= rd_go;
            best_found_reg <= best_found_next;
            slot_found_reg <= slot_found_next;
            me_found_reg   <= me_found_next;
            nb_found_reg   <= nb_found_next;
            left_found_reg <= left_found_next;
        end
        rd_idx_reg     <= cnt_reg[IDX_W-1:0];
        best_idx_reg   <= best_idx_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
        slot_idx_reg   <= slot_idx_next;
        me_idx_reg     <= me_idx_next;
        me_start_reg   <= me_start_next;
        me_len_reg     <= me_len_next;
        nb_idx_reg     <= nb_idx_next;
        nb_len_reg     <= nb_len_next;
        nb_used_reg    <= nb_used_next;
        left_idx_reg   <= left_idx_next;
        left_len_reg   <= left_len_next;
    end

    // result register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.result_load) begin
            m_status_reg <= cmd.status;
            m_off_reg    <= (cmd.status == ST_OK && kind_reg == KIND_ALLOC) ?
                            best_start_reg[15:0] : 16'd0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_payload_offset = m_off_reg;
    assign m_status         = m_status_reg;

    assign sts.cfg_wr     = cfg_valid;
    assign sts.kind       = kind_reg;
    assign sts.null_off   = (s_kind == KIND_FREE) && (s_block_offset == 16'd0);
    assign sts.scan_done  = !rd_pend_reg && (cnt_reg == CNT_W'(MAX_BLOCKS));
    assign sts.best_found = best_found_reg;
    assign sts.need_split = need_split;
    assign sts.slot_found = slot_found_reg;
    assign sts.me_ok      = me_found_reg && used_reg[me_idx_reg];
    assign sts.out_busy   = m_valid_reg && !m_ready;

endmodule

[rtl/bfba_ctrl.sv]
// ----------------------------------------------------------------------------
// Best-fit block allocator controller
// Sequences table init, the find scan, the neighbor scan, table writes and
// the result handoff.
// ----------------------------------------------------------------------------
module bfba_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bfba_pkg::sts_t sts,
    output bfba_pkg::cmd_t cmd
);
    import bfba_pkg::*;

    state_t  state_reg, state_next;
    logic    init_pending_reg, init_pending_next;
    status_t status_reg, status_next;

    assign s_ready = (state_reg == S_IDLE) && !init_pending_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_INIT;
            init_pending_reg <= 1'b0;
            status_reg       <= ST_OK;
        end else begin
            state_reg        <= state_next;
            init_pending_reg <= init_pending_next;
            status_reg       <= status_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.phase   = PH_FIND;
        cmd.status  = status_reg;
        if (sts.cfg_wr) begin
            init_pending_next = 1'b1;
        end else if (state_reg == S_INIT) begin
            init_pending_next = 1'b0;
        end else begin
            init_pending_next = init_pending_reg;
        end
        unique case (state_reg)
            S_INIT: begin
                cmd.init   = 1'b1;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (init_pending_reg) begin
                    state_next = S_INIT;
                end else if (s_valid) begin
                    cmd.accept     = 1'b1;
                    cmd.scan_clear = 1'b1;
                    if (sts.null_off) begin
                        status_next = ST_BADFREE;
                        state_next  = S_RESULT;
                    end else begin
                        state_next = S_SCAN_A;
                    end
                end
            end
            S_SCAN_A: begin
                cmd.scan_en = 1'b1;
                if (sts.scan_done) begin
                    if (sts.kind == KIND_ALLOC) begin
                        if (!sts.best_found) begin
                            status_next = ST_NOFIT;
                            state_next  = S_RESULT;
                        end else if (sts.need_split && !sts.slot_found) begin
                            status_next = ST_FULL;
                            state_next  = S_RESULT;
                        end else if (sts.need_split) begin
                            state_next = S_WR_SPLIT;
                        end else begin
                            state_next = S_WR_BEST;
                        end
                    end else if (!sts.me_ok) begin
                        status_next = ST_BADFREE;
                        state_next  = S_RESULT;
                    end else begin
                        cmd.scan_rewind = 1'b1;
                        state_next      = S_SCAN_B;
                    end
                end
            end
            S_SCAN_B: begin
                cmd.scan_en = 1'b1;
                cmd.phase   = PH_NEIGHBOR;
                if (sts.scan_done) begin
                    state_next = S_WR_FREE;
                end
            end
            S_WR_SPLIT: begin
                cmd.wr_split = 1'b1;
                state_next   = S_WR_BEST;
            end
            S_WR_BEST: begin
                cmd.wr_best = 1'b1;
                status_next = ST_OK;
                state_next  = S_RESULT;
            end
            S_WR_FREE: begin
                cmd.wr_free = 1'b1;
                status_next = ST_OK;
                state_next  = S_RESULT;
            end
            S_RESULT: begin
                if (!sts.out_busy) begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load |-> !sts.out_busy)
        else $error("result loaded over an unsent result");

    a_accept_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_SCAN_A || state_reg == S_RESULT))
        else $error("accepted request not processed");

    a_cfg_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (sts.cfg_wr && state_reg == S_IDLE) |=> !s_ready)
        else $error("request taken before table re-init");

endmodule

[rtl/best_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// Best-fit block allocator
// Allocates and frees blocks of a byte pool with best fit and coalescing.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_ready/cfg_pool_size sets the pool size; cfg_ready is always
//   high. Each write rebuilds the table as one free block (none if pool <= 8).
//   s_* carries one request (allocate or free); m_* returns one result per
//   request: payload offset and status.
//   Scan: an allocate is one full pass over the 64-entry block table, read
//   one entry per cycle from the table memory's single read port; a free
//   takes a pass to find the block and a second pass for its neighbors
//   (one pass for a bad offset); a null free answers with no pass.
//   One request is in flight at a time; the next is taken once the result
//   of the last one is loaded into the output register.
//   Reset: the table holds one free block covering the 65536-byte pool; the
//   rebuild runs in the first cycle after reset, then s_ready rises.
//   Stall: a finished result holds in the output register until m_ready;
//   the next request may be taken meanwhile and waits in its final state.
// ----------------------------------------------------------------------------
module best_fit_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_pool_size,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [16:0] s_request_size,
    input  logic [15:0] s_block_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_payload_offset,
    output logic [1:0]  m_status
);
    import bfba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bfba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bfba_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_pool_size    (cfg_pool_size),
        .s_kind           (s_kind),
        .s_request_size   (s_request_size),
        .s_block_offset   (s_block_offset),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_payload_offset (m_payload_offset),
        .m_status         (m_status),
        .cmd              (cmd),
        .sts              (sts)
    );

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Best-fit block allocator testbench
// Drives allocate and free requests through the request channel, predicts
// each grant and status with a table model of its own, and compares every
// result in order. Covers several pool sizes, table exhaustion and stalls.
// ----------------------------------------------------------------------------
module tb;
    import bfba_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_pool_size = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = KIND_ALLOC;
    logic [16:0] s_request_size = '0;
    logic [15:0] s_block_offset = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_payload_offset;
    logic [1:0]  m_status;

    best_fit_block_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_pool_size(cfg_pool_size),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_request_size(s_request_size), .s_block_offset(s_block_offset),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_payload_offset(m_payload_offset), .m_status(m_status)
    );

    always #4 aclk = ~aclk;

    typedef struct {
        logic [15:0] offset;
        status_t     status;
    } grant_t;

    // Block table mirror
    logic [16:0] blk_start [MAX_BLOCKS];
    logic [16:0] blk_len   [MAX_BLOCKS];
    bit          blk_used  [MAX_BLOCKS];
    bit          blk_valid [MAX_BLOCKS];

    grant_t      grant_q[$];
    logic [15:0] live_q[$];     // offsets currently allocated
    int          n_fail = 0;
    int          n_checked = 0;
    int          n_sent = 0;
    int          status_seen[4] = '{0, 0, 0, 0};
    bit          rx_free_run = 0;
    bit          rx_hold = 0;
    bit          tx_free_run = 0;
    int          idle_count = 0;

    function automatic void rebuild_table(logic [16:0] psize);
        int total;
        total = (psize > POOL_MAX_BYTES) ? POOL_MAX_BYTES : int'(psize);
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            blk_start[i] = '0; blk_len[i] = '0;
            blk_used[i] = 0; blk_valid[i] = 0;
        end
        if (total > HEADER_BYTES) begin
            blk_start[0] = 17'(HEADER_BYTES);
            blk_len[0] = 17'(total - HEADER_BYTES);
            blk_valid[0] = 1;
        end
        live_q.delete();
    endfunction

    function automatic int lookup_start(int start);
        for (int i = 0; i < MAX_BLOCKS; i++)
            if (blk_valid[i] && blk_start[i] == start) return i;
        return -1;
    endfunction

    function automatic grant_t allocate_block(int req);
        grant_t g;
        int best, slot, len;
        best = -1; slot = -1;
        g.offset = '0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (!blk_valid[i] || blk_used[i] || blk_len[i] < req) continue;
            if (best < 0 || blk_len[i] < blk_len[best] ||
                (blk_len[i] == blk_len[best] && blk_start[i] < blk_start[best]))
                best = i;
        end
        if (best < 0) begin
            g.status = ST_NOFIT;
            return g;
        end
        len = int'(blk_len[best]);
        if (req + HEADER_BYTES < len) begin
            for (int i = 0; i < MAX_BLOCKS; i++)
                if (!blk_valid[i]) begin slot = i; break; end
            if (slot < 0) begin
                g.status = ST_FULL;
                return g;
            end
            blk_valid[slot] = 1;
            blk_used[slot] = 0;
            blk_start[slot] = 17'(blk_start[best] + req + HEADER_BYTES);
            blk_len[slot] = 17'(len - req - HEADER_BYTES);
            blk_len[best] = 17'(req);
        end
        blk_used[best] = 1;
        g.offset = blk_start[best][15:0];
        g.status = ST_OK;
        live_q.push_back(g.offset);
        return g;
    endfunction

    function automatic status_t release_block(int off);
        int me, nb;
        if (off == 0) return ST_BADFREE;
        me = lookup_start(off);
        if (me < 0 || !blk_used[me]) return ST_BADFREE;
        blk_used[me] = 0;
        foreach (live_q[k])
            if (live_q[k] == off) begin live_q.delete(k); break; end
        nb = lookup_start(blk_start[me] + blk_len[me] + HEADER_BYTES);
        if (nb >= 0 && !blk_used[nb]) begin
            blk_len[me] = 17'(blk_len[me] + blk_len[nb] + HEADER_BYTES);
            blk_valid[nb] = 0; blk_start[nb] = '0; blk_len[nb] = '0;
        end
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (i == me || !blk_valid[i] || blk_used[i]) continue;
            if (blk_start[i] + blk_len[i] + HEADER_BYTES == blk_start[me]) begin
                blk_len[i] = 17'(blk_len[i] + blk_len[me] + HEADER_BYTES);
                blk_valid[me] = 0; blk_start[me] = '0; blk_len[me] = '0;
                break;
            end
        end
        return ST_OK;
    endfunction

    // Send one request, predict it, and optionally pin the expected result
    task automatic send_request(logic kind, logic [16:0] req, logic [15:0] off,
                                bit pinned, logic [15:0] pin_off, status_t pin_st);
        grant_t g;
        if (!tx_free_run && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (!tx_free_run && $urandom_range(99) < 12);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_request_size <= req;
        s_block_offset <= off;
        do @(posedge aclk); while (!s_ready);
        if (kind == KIND_ALLOC) begin
            g = allocate_block(int'(req));
        end else begin
            g.offset = '0;
            g.status = release_block(int'(off));
        end
        if (pinned && (g.offset !== pin_off || g.status !== pin_st)) begin
            $error("predictor disagrees with table row: offset %0d status %0d",
                   g.offset, g.status);
            n_fail++;
        end
        grant_q.push_back(g);
        n_sent++;
        // keep valid high; the next request or an idle gap decides what follows
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_pool(logic [16:0] psize);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_pool_size <= psize;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rebuild_table(psize);
        repeat (4) @(posedge aclk);
    endtask

    // Random traffic: mostly allocs of modest size and frees of live blocks
    task automatic random_traffic(int count, int max_req);
        logic [16:0] req;
        logic [15:0] off;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                req = (pick < 3) ? 17'($urandom) : 17'($urandom_range(max_req));
                send_request(KIND_ALLOC, req, '0, 0, '0, ST_OK);
            end else if (pick < 92 && live_q.size() != 0) begin
                off = live_q[$urandom_range(live_q.size() - 1)];
                send_request(KIND_FREE, 17'($urandom), off, 0, '0, ST_OK);
            end else begin
                off = (pick < 95) ? 16'($urandom) : 16'($urandom_range(HEADER_BYTES * 40));
                send_request(KIND_FREE, 17'($urandom), off, 0, '0, ST_OK);
            end
        end
    endtask

    typedef struct {
        logic        kind;
        logic [16:0] req;
        logic [15:0] off;
        bit          pinned;
        logic [15:0] exp_off;
        status_t     exp_st;
    } row_t;

    row_t directed_rows[] = '{
        '{KIND_FREE,  17'd0,     16'd0,     1, 16'd0,     ST_BADFREE},  // null free
        '{KIND_FREE,  17'd0,     16'd8,     1, 16'd0,     ST_BADFREE},  // free of free block
        '{KIND_ALLOC, 17'd65536, 16'd0,     1, 16'd0,     ST_NOFIT},    // too large
        '{KIND_ALLOC, 17'd0,     16'd0,     1, 16'd8,     ST_OK},       // zero size
        '{KIND_ALLOC, 17'd100,   16'd0,     1, 16'd16,    ST_OK},
        '{KIND_ALLOC, 17'd200,   16'd0,     1, 16'd124,   ST_OK},
        '{KIND_FREE,  17'h1ffff, 16'd116,   1, 16'd0,     ST_BADFREE},  // not a block start
        '{KIND_FREE,  17'd0,     16'd16,    1, 16'd0,     ST_OK},
        '{KIND_ALLOC, 17'd50,    16'd0,     0, 16'd0,     ST_OK},       // best fit in hole
        '{KIND_FREE,  17'd0,     16'd16,    1, 16'd0,     ST_OK},
        '{KIND_FREE,  17'd0,     16'd16,    1, 16'd0,     ST_BADFREE},  // double free
        '{KIND_FREE,  17'd0,     16'd124,   1, 16'd0,     ST_OK},
        '{KIND_FREE,  17'd0,     16'd8,     1, 16'd0,     ST_OK},       // merge all back
        '{KIND_ALLOC, 17'd65528, 16'd0,     1, 16'd8,     ST_OK},       // whole pool
        '{KIND_FREE,  17'd0,     16'hffff,  1, 16'd0,     ST_BADFREE},
        '{KIND_FREE,  17'd0,     16'd8,     1, 16'd0,     ST_OK}
    };

    // Result checker and receiver stalls
    always @(posedge aclk) begin
        grant_t g;
        if (aresetn && m_valid && m_ready) begin
            if (grant_q.size() == 0) begin
                $error("unexpected result: offset %0d status %0d",
                       m_payload_offset, m_status);
                n_fail++;
            end else begin
                g = grant_q.pop_front();
                if (m_payload_offset !== g.offset) begin
                    $error("payload_offset expected %0d actual %0d",
                           g.offset, m_payload_offset);
                    n_fail++;
                end
                if (m_status !== g.status) begin
                    $error("status expected %0d actual %0d", g.status, m_status);
                    n_fail++;
                end
                status_seen[g.status]++;
                n_checked++;
            end
        end
        m_ready <= !rx_hold && (rx_free_run || $urandom_range(99) >= 12);
    end

    // Watchdog: count cycles with no transfer on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        rebuild_table(17'd65536);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r])
            send_request(directed_rows[r].kind, directed_rows[r].req, directed_rows[r].off,
                         directed_rows[r].pinned, directed_rows[r].exp_off,
                         directed_rows[r].exp_st);

        // Small pools: too small, minimum, and a pool that caps above the max
        write_pool(17'd8);
        send_request(KIND_ALLOC, 17'd0, '0, 1, '0, ST_NOFIT);
        write_pool(17'd9);
        send_request(KIND_ALLOC, 17'd0, '0, 1, 16'd8, ST_OK);
        send_request(KIND_ALLOC, 17'd0, '0, 1, '0, ST_NOFIT);
        write_pool(17'h1ffff);
        // fill the table with tiny blocks until it reports full
        for (int n = 0; n < 66; n++)
            send_request(KIND_ALLOC, 17'($urandom_range(3)), '0, 0, '0, ST_OK);

        // Receiver holds off while requests keep coming
        write_pool(17'd65536);
        rx_hold = 1;
        fork
            begin repeat (600) @(posedge aclk); rx_hold = 0; end
            begin random_traffic(12, 2000); s_valid <= 1'b0; end
        join

        // Sender pauses until everything has come back
        while (grant_q.size() != 0) @(posedge aclk);

        write_pool(17'd4096);
        random_traffic(500, 300);
        write_pool(17'd600);
        random_traffic(300, 60);

        // Stretch with no idling on either side
        tx_free_run = 1; rx_free_run = 1;
        write_pool(17'd65536);
        random_traffic(200, 4000);
        tx_free_run = 0; rx_free_run = 0;

        random_traffic(500, 1500);
        write_pool(17'd20000);
        random_traffic(300, 800);

        drain_results();
        $display("sent %0d requests, checked %0d results", n_sent, n_checked);
        $display("status counts: ok %0d, nofit %0d, badfree %0d, full %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (n_fail == 0 && grant_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[best_fit_block_allocator.f]
rtl/bfba_pkg.sv
rtl/bfba_datapath.sv
rtl/bfba_ctrl.sv
rtl/best_fit_block_allocator.sv
sim/tb.sv
